// ----- design/key_auto_repeat_top_assert.svh -----
// assertion macros for the checker of the key auto-repeat block
`ifndef KEY_AUTO_REPEAT_TOP_ASSERT_SVH
`define KEY_AUTO_REPEAT_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define KAR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("key auto-repeat check failed");

// next-cycle implication, off during reset
`define KAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("key auto-repeat check failed");

`endif

// ----- design/kar_pkg.sv -----
`default_nettype none

package kar_pkg;

  localparam int MASK_BITS = 10;
  localparam int SLOT_W    = 4;
  localparam int TICK_W    = 32;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int RATE_W    = 2;
  localparam int SCALED_W  = 18;
  localparam int PROD_W    = SCALED_W + CNT_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_RATE     = 2'd2
  } cfg_reg_t;

  localparam logic [RATE_W-1:0] RATE_X2 = 2'd0;
  localparam logic [RATE_W-1:0] RATE_X3 = 2'd1;
  localparam logic [RATE_W-1:0] RATE_X1 = 2'd2;

  // tick value scaled by the frame rate mode
  function automatic logic [SCALED_W-1:0] rate_scale(input logic [CFG_W-1:0] v,
                                                     input logic [RATE_W-1:0] mode);
    logic [SCALED_W-1:0] v1;
    logic [SCALED_W-1:0] v2;
    v1 = SCALED_W'(v);
    v2 = {v1[SCALED_W-2:0], 1'b0};
    case (mode)
      RATE_X2: rate_scale = v2;
      RATE_X3: rate_scale = v2 + v1;
      RATE_X1: rate_scale = v1;
      default: rate_scale = v1;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- design/kar_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle
module kar_div import kar_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [TICK_W-1:0]   dividend,
  input  wire logic [SCALED_W-1:0] divisor,
  output logic                     done,
  output logic [TICK_W-1:0]        quotient
);

  localparam int STEP_W = $clog2(TICK_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TICK_W - 1);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [SCALED_W-1:0] rem;
  logic [TICK_W-1:0]   quot;
  logic [SCALED_W:0]   trial;
  logic                take;

  assign trial    = {rem, quot[TICK_W-1]};
  assign take     = trial >= {1'b0, divisor};
  assign quotient = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
      rem  <= '0;
      quot <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quot <= dividend;
      end else if (busy) begin
        if (take) begin
          rem <= SCALED_W'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[SCALED_W-1:0];
        end
        quot <= {quot[TICK_W-2:0], take};
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/key_auto_repeat_top.sv -----
// Key auto-repeat (typematic) engine. Each request reports one key slot: held,
// pressed this frame, the current tick and the key's press stamp. A fresh press
// fires at once and zeroes the slot's repeat counter; a held key fires once the
// elapsed ticks pass the scaled delay by at least the scaled interval times the
// counter, and the counter then becomes the whole intervals past the delay plus
// one (saturating at 65535, or 1 for a zero interval). Every fire sets the slot's
// bit in the frame mask, which clears on frame_start. One request is worked on at
// a time and in_stall is high while it is in flight. A request passes through
// accept, scale/multiply, compare and write back when no division is needed; a
// held key that fires on the interval also waits on the shared 32-step divider,
// which produces one quotient bit per cycle. A finished result sits in the
// output register, so the next request can be accepted while it waits; write
// back of the following result waits for that register to empty. Configuration
// writes are registered and are to be made while idle.
`default_nettype none

module key_auto_repeat_top import kar_pkg::*; #(
  parameter int NUM_KEYS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration write port
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 frame_start,
  input  wire logic [SLOT_W-1:0]    key_slot,
  input  wire logic                 key_held,
  input  wire logic                 key_pressed,
  input  wire logic [TICK_W-1:0]    now_tick,
  input  wire logic [TICK_W-1:0]    press_stamp,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [SLOT_W-1:0]         slot_out,
  output logic                      repeat_fire,
  output logic [MASK_BITS-1:0]      frame_mask
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_CMP,
    S_DIV,
    S_DONE
  } state_t;

  // configuration registers
  logic [CFG_W-1:0]  repeat_delay;
  logic [CFG_W-1:0]  repeat_interval;
  logic [RATE_W-1:0] rate_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay    <= '0;
      repeat_interval <= '0;
      rate_mode       <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELAY:    repeat_delay    <= cfg_data;
        REG_INTERVAL: repeat_interval <= cfg_data;
        REG_RATE:     rate_mode       <= cfg_data[RATE_W-1:0];
        default:      ;
      endcase
    end
  end

  state_t              state;
  logic [CNT_W-1:0]    repeat_count [NUM_KEYS];
  logic [MASK_BITS-1:0] mask_reg;

  // request latched at accept
  logic [SLOT_W-1:0]   slot_q;
  logic                slot_ok_q;
  logic                frame_start_q;
  logic                held_q;
  logic                pressed_q;
  logic [TICK_W-1:0]   elapsed;
  logic [CNT_W-1:0]    count_q;

  // evaluation results
  logic [TICK_W-1:0]   past;
  logic                ge_delay;
  logic [SCALED_W-1:0] sint_q;
  logic [PROD_W-1:0]   need;
  logic                fire_q;
  logic                cnt_we;
  logic [CNT_W-1:0]    count_new;

  logic                slot_ok;
  logic [SCALED_W-1:0] sdelay;
  logic [SCALED_W-1:0] sint;
  logic [TICK_W:0]     diff;
  logic                fire_now;
  logic                need_div;
  logic                div_start;
  logic                div_done;
  logic [TICK_W-1:0]   quotient;
  logic [MASK_BITS-1:0] mask_new;
  logic                out_free;

  // slot must be a real key and fit in the mask
  assign slot_ok = ({1'b0, key_slot} < (SLOT_W + 1)'(NUM_KEYS)) &&
                   ({1'b0, key_slot} < (SLOT_W + 1)'(MASK_BITS));

  assign sdelay = rate_scale(repeat_delay, rate_mode);
  assign sint   = rate_scale(repeat_interval, rate_mode);
  assign diff   = {1'b0, elapsed} - (TICK_W + 1)'(sdelay);

  // fire decision, made once past and need are registered
  assign fire_now = slot_ok_q && held_q &&
                    (pressed_q || (ge_delay && (PROD_W'(past) >= need)));
  assign need_div  = fire_now && !pressed_q && (sint_q != '0);
  assign div_start = (state == S_CMP) && need_div;

  assign mask_new = (frame_start_q ? '0 : mask_reg) |
                    (fire_q ? (MASK_BITS'(1) << slot_q) : '0);

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  kar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (past),
    .divisor  (sint_q),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mask_reg      <= '0;
      out_valid     <= 1'b0;
      slot_out      <= '0;
      repeat_fire   <= 1'b0;
      frame_mask    <= '0;
      slot_q        <= '0;
      slot_ok_q     <= 1'b0;
      frame_start_q <= 1'b0;
      held_q        <= 1'b0;
      pressed_q     <= 1'b0;
      elapsed       <= '0;
      count_q       <= '0;
      past          <= '0;
      ge_delay      <= 1'b0;
      sint_q        <= '0;
      need          <= '0;
      fire_q        <= 1'b0;
      cnt_we        <= 1'b0;
      count_new     <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        repeat_count[k] <= '0;
      end
    end else begin
      // result taken downstream, unless a new one is loaded this cycle
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            slot_q        <= key_slot;
            slot_ok_q     <= slot_ok;
            frame_start_q <= frame_start;
            held_q        <= key_held;
            pressed_q     <= key_pressed;
            elapsed       <= now_tick - press_stamp;
            count_q       <= slot_ok ? repeat_count[key_slot[IDX_W-1:0]] : '0;
            state         <= S_EVAL;
          end
        end

        // scale delay and interval, threshold product
        S_EVAL: begin
          past     <= diff[TICK_W-1:0];
          ge_delay <= !diff[TICK_W];
          sint_q   <= sint;
          need     <= PROD_W'(sint) * PROD_W'(count_q);
          state    <= S_CMP;
        end

        S_CMP: begin
          fire_q <= fire_now;
          cnt_we <= fire_now;
          if (need_div) begin
            state <= S_DIV;
          end else begin
            // fresh press zeroes, zero interval pins the counter at one
            count_new <= pressed_q ? '0 : CNT_W'(1);
            state     <= S_DONE;
          end
        end

        S_DIV: begin
          if (div_done) begin
            if (quotient >= TICK_W'(CNT_MAX)) begin
              count_new <= CNT_MAX;
            end else begin
              count_new <= quotient[CNT_W-1:0] + 1'b1;
            end
            state <= S_DONE;
          end
        end

        // commit state and present the result
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            slot_out    <= slot_q;
            repeat_fire <= fire_q;
            frame_mask  <= mask_new;
            mask_reg    <= mask_new;
            if (cnt_we) begin
              repeat_count[slot_q[IDX_W-1:0]] <= count_new;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/kar_checker.sv -----
`default_nettype none

`include "key_auto_repeat_top_assert.svh"

module kar_checker import kar_pkg::*; #(
  parameter int NUM_KEYS = 10
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [SLOT_W-1:0]    slot_out,
  input wire logic                 repeat_fire,
  input wire logic [MASK_BITS-1:0] frame_mask
);

  // a held result does not change under stall
  `KAR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(slot_out) && $stable(repeat_fire) && $stable(frame_mask))

  // one request in flight at a time
  `KAR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a fire always shows up in the frame mask
  `KAR_ASSERT_NOW(a_fire_in_mask, out_valid && repeat_fire,
    (frame_mask & (MASK_BITS'(1) << slot_out)) != '0)

  // only real key slots fire
  `KAR_ASSERT_NOW(a_fire_slot_range, out_valid && repeat_fire,
    ({1'b0, slot_out} < (SLOT_W + 1)'(NUM_KEYS)))

endmodule

bind key_auto_repeat_top kar_checker #(.NUM_KEYS(NUM_KEYS)) u_kar_checker (.*);

`default_nettype wire
